### design/pbd_pkg.sv
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types and constants for the point to box distance pipeline.
// ----------------------------------------------------------------------------
package pbd_pkg;

    // Register stages in the difference and band front end.
    localparam int PBD_FRONT_LAT  = 3;
    // Register stages in the square and sum section.
    localparam int PBD_SQUARE_LAT = 2;

    // Band membership of the point, one flag per axis.
    typedef struct packed {
        logic x_in;
        logic y_in;
    } t_band;

    // Total cycles from an accepted start to the result strobe. The root
    // section retires one result bit per stage, coord_bits + 1 stages.
    function automatic int pbd_latency(input int coord_bits);
        return PBD_FRONT_LAT + PBD_SQUARE_LAT + coord_bits + 1;
    endfunction

endpackage

### design/point_to_box_distance_top.sv
// ----------------------------------------------------------------------------
// point_to_box_distance_top
// Distance from a point to an axis-aligned rectangle, fixed point, pipelined.
// ----------------------------------------------------------------------------
// Path: an accepted start passes the front end, then the squaring section,
// then the square root pipeline, which decides the result bits one by one
// from the top bit down, and leaves on o_done.
// Throughput: one transfer per cycle; busy is never raised.
// Reset: synchronous, active low; it clears every valid bit so no strobe
// leaves the block until a new item has gone through the whole pipeline.
// ----------------------------------------------------------------------------
module point_to_box_distance_top #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_rect_left,
    input  logic signed [COORD_BITS-1:0] i_rect_top,
    input  logic signed [COORD_BITS-1:0] i_rect_right,
    input  logic signed [COORD_BITS-1:0] i_rect_bottom,
    output logic                         o_done,
    output logic [COORD_BITS:0]          o_distance_out
);

    // The nearest corner distance separates per axis: the smallest of the
    // four corner sums of squares equals the square of the nearer x gap plus
    // the square of the nearer y gap. Forcing a gap to zero when the point is
    // inside that axis band then covers the band and inside cases too, since
    // the square root of a perfect square is exact. Every item therefore takes
    // the same path and the pipeline has no branches.

    logic                   front_vld;
    logic [COORD_BITS-1:0]  front_dx;
    logic [COORD_BITS-1:0]  front_dy;
    logic                   sq_vld;
    logic [2*COORD_BITS:0]  sq_sum;

    // Nothing inside can hold an item back, so every start is a transfer.
    assign busy = 1'b0;

    // Front end: differences, magnitudes, band tests, nearest gaps.
    pbd_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (start),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_rect_left   (i_rect_left),
        .i_rect_top    (i_rect_top),
        .i_rect_right  (i_rect_right),
        .i_rect_bottom (i_rect_bottom),
        .o_valid       (front_vld),
        .o_dx          (front_dx),
        .o_dy          (front_dy)
    );

    // Squares are registered before the sum so the multipliers and the wide
    // adder sit in separate register stages.
    pbd_square #(
        .COORD_BITS (COORD_BITS)
    ) u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_vld),
        .i_dx    (front_dx),
        .i_dy    (front_dy),
        .o_valid (sq_vld),
        .o_sum   (sq_sum)
    );

    // The root's last stage register drives the result ports directly, and
    // the result is the floor of the exact distance in the input scale.
    pbd_sqrt #(
        .COORD_BITS (COORD_BITS)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (sq_vld),
        .i_radicand (sq_sum),
        .o_valid    (o_done),
        .o_root     (o_distance_out)
    );

endmodule

### design/pbd_front.sv
// ----------------------------------------------------------------------------
// pbd_front
// Edge differences, magnitudes, band tests and the nearest gap per axis.
// ----------------------------------------------------------------------------
module pbd_front #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_rect_left,
    input  logic signed [COORD_BITS-1:0] i_rect_top,
    input  logic signed [COORD_BITS-1:0] i_rect_right,
    input  logic signed [COORD_BITS-1:0] i_rect_bottom,
    output logic                         o_valid,
    output logic [COORD_BITS-1:0]        o_dx,
    output logic [COORD_BITS-1:0]        o_dy
);
    import pbd_pkg::*;

    localparam int C = COORD_BITS;

    // Stage A: signed differences, one bit wider than the coordinates.
    logic               r_vld_a;
    logic signed [C:0]  r_dxl, r_dxr, r_dyt, r_dyb;

    // Stage B: magnitudes and band flags.
    logic               r_vld_b;
    logic [C-1:0]       r_axl, r_axr, r_ayt, r_ayb;
    t_band              r_band;
    t_band              n_band;

    // Stage C: nearest gap per axis, zero when the point lies in that band.
    logic               r_vld_c;
    logic [C-1:0]       r_dx, r_dy;

    logic signed [C:0]  n_nxl, n_nxr, n_nyt, n_nyb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
        end else begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dxl <= (C+1)'(i_point_x) - (C+1)'(i_rect_left);
        r_dxr <= (C+1)'(i_point_x) - (C+1)'(i_rect_right);
        r_dyt <= (C+1)'(i_point_y) - (C+1)'(i_rect_top);
        r_dyb <= (C+1)'(i_point_y) - (C+1)'(i_rect_bottom);
    end

    always_comb begin
        n_nxl = -r_dxl;
        n_nxr = -r_dxr;
        n_nyt = -r_dyt;
        n_nyb = -r_dyb;
        // Inside a band means at or past the low edge and at or before the high edge.
        n_band.x_in = !r_dxl[C] && (r_dxr[C] || (r_dxr == '0));
        n_band.y_in = !r_dyt[C] && (r_dyb[C] || (r_dyb == '0));
    end

    always_ff @(posedge i_clk) begin
        r_axl  <= r_dxl[C] ? n_nxl[C-1:0] : r_dxl[C-1:0];
        r_axr  <= r_dxr[C] ? n_nxr[C-1:0] : r_dxr[C-1:0];
        r_ayt  <= r_dyt[C] ? n_nyt[C-1:0] : r_dyt[C-1:0];
        r_ayb  <= r_dyb[C] ? n_nyb[C-1:0] : r_dyb[C-1:0];
        r_band <= n_band;
    end

    always_ff @(posedge i_clk) begin
        if (r_band.x_in) begin
            r_dx <= '0;
        end else begin
            r_dx <= (r_axl < r_axr) ? r_axl : r_axr;
        end
        if (r_band.y_in) begin
            r_dy <= '0;
        end else begin
            r_dy <= (r_ayt < r_ayb) ? r_ayt : r_ayb;
        end
    end

    assign o_valid = r_vld_c;
    assign o_dx    = r_dx;
    assign o_dy    = r_dy;

endmodule

### design/pbd_square.sv
// ----------------------------------------------------------------------------
// pbd_square
// Squares of the two axis gaps and their sum, two register stages.
// ----------------------------------------------------------------------------
module pbd_square #(
    parameter int COORD_BITS = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [COORD_BITS-1:0]   i_dx,
    input  logic [COORD_BITS-1:0]   i_dy,
    output logic                    o_valid,
    output logic [2*COORD_BITS:0]   o_sum
);
    localparam int C = COORD_BITS;

    logic             r_vld_d, r_vld_e;
    logic [2*C-1:0]   r_sqx, r_sqy;
    logic [2*C:0]     r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_d <= 1'b0;
            r_vld_e <= 1'b0;
        end else begin
            r_vld_d <= i_valid;
            r_vld_e <= r_vld_d;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sqx <= (2*C)'(i_dx) * (2*C)'(i_dx);
        r_sqy <= (2*C)'(i_dy) * (2*C)'(i_dy);
        r_sum <= (2*C+1)'(r_sqx) + (2*C+1)'(r_sqy);
    end

    assign o_valid = r_vld_e;
    assign o_sum   = r_sum;

endmodule

### design/pbd_sqrt.sv
// ----------------------------------------------------------------------------
// pbd_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module pbd_sqrt #(
    parameter int COORD_BITS = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [2*COORD_BITS:0]   i_radicand,
    output logic                    o_valid,
    output logic [COORD_BITS:0]     o_root
);
    localparam int R = COORD_BITS + 1;

    // Stage k holds the state after result bit R-1-k has been decided.
    logic             r_vld  [0:R-1];
    logic [R+1:0]     r_rem  [0:R-1];
    logic [R-1:0]     r_root [0:R-1];
    logic [2*R-1:0]   r_rad  [0:R-1];

    genvar k;
    generate
        for (k = 0; k < R; k++) begin : g_stage
            logic           vld_in;
            logic [R+1:0]   rem_in;
            logic [R-1:0]   root_in;
            logic [2*R-1:0] rad_in;
            logic [R+1:0]   rem_sh;
            logic [R+1:0]   trial;
            logic [R+2:0]   diff;
            logic           take;

            if (k == 0) begin : g_first
                assign vld_in  = i_valid;
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = {1'b0, i_radicand};
            end else begin : g_next
                assign vld_in  = r_vld[k-1];
                assign rem_in  = r_rem[k-1];
                assign root_in = r_root[k-1];
                assign rad_in  = r_rad[k-1];
            end

            // Bring down the next two radicand bits and try root*4 + 1.
            assign rem_sh = {rem_in[R-1:0], rad_in[2*R-1 -: 2]};
            assign trial  = {root_in, 2'b01};
            assign diff   = {1'b0, rem_sh} - {1'b0, trial};
            assign take   = !diff[R+2];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[k]  <= take ? diff[R+1:0] : rem_sh;
                r_root[k] <= {root_in[R-2:0], take};
                r_rad[k]  <= {rad_in[2*R-3:0], 2'b00};
            end
        end
    endgenerate

    assign o_valid = r_vld[R-1];
    assign o_root  = r_root[R-1];

endmodule

### design/pbd_checker.sv
// ----------------------------------------------------------------------------
// pbd_checker
// Port-level checks of timing and corner results, bound to the top level.
// ----------------------------------------------------------------------------
module pbd_checker #(
    parameter int COORD_BITS = 24
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic signed [COORD_BITS-1:0] i_point_x,
    input logic signed [COORD_BITS-1:0] i_point_y,
    input logic signed [COORD_BITS-1:0] i_rect_left,
    input logic signed [COORD_BITS-1:0] i_rect_top,
    input logic signed [COORD_BITS-1:0] i_rect_right,
    input logic signed [COORD_BITS-1:0] i_rect_bottom,
    input logic                         o_done,
    input logic [COORD_BITS:0]          o_distance_out
);
    import pbd_pkg::*;

    localparam int LAT = pbd_latency(COORD_BITS);
    localparam int CW  = $clog2(LAT + 1);

    // Counts edges since reset so history from before reset is ignored.
    logic [CW-1:0] r_cnt;
    logic          acc;
    logic          on_corner;

    assign acc       = start && !busy;
    assign on_corner = (i_point_x == i_rect_left) && (i_point_y == i_rect_top);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_cnt != CW'(LAT)) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Each transfer gives exactly one strobe, after the latency from pbd_latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CW'(LAT)) |-> (o_done == $past(acc, LAT)))
        else $error("result strobe does not match transfer history");

    // A point on the top left corner is on the boundary and gives zero.
    a_corner_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_cnt == CW'(LAT)) && $past(acc && on_corner, LAT))
            |-> (o_distance_out == '0))
        else $error("point on the rectangle corner gave a nonzero distance");

    // Reset empties the pipeline.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    // The block never holds off a transfer.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind point_to_box_distance_top pbd_checker #(
    .COORD_BITS (COORD_BITS)
) u_pbd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_point_x      (i_point_x),
    .i_point_y      (i_point_y),
    .i_rect_left    (i_rect_left),
    .i_rect_top     (i_rect_top),
    .i_rect_right   (i_rect_right),
    .i_rect_bottom  (i_rect_bottom),
    .o_done         (o_done),
    .o_distance_out (o_distance_out)
);
